>>> sv/signal_pending_delivery_controller_defines.svh
// Assertion macros used by the checker file.
// Depends on nothing; the caller supplies clk and rst in scope.
`ifndef SIGNAL_PENDING_DELIVERY_CONTROLLER_DEFINES_SVH
`define SIGNAL_PENDING_DELIVERY_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPDC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spdc check failed: same-cycle rule");

// Next-cycle implication, disabled during reset.
`define SPDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spdc check failed: next-cycle rule");

`endif

>>> sv/spdc_pkg.sv
// Package for the signal pending/delivery controller: types, codes, helpers.
// Used by every module of the block except spdc_ram; depends on nothing.
package spdc_pkg;

  localparam int SIGNAL_COUNT_DEF = 64;

  localparam logic [5:0] SIG_KILL = 6'd9;
  localparam logic [5:0] SIG_CONT = 6'd18;
  localparam logic [5:0] SIG_STOP = 6'd19;
  localparam logic [7:0] EXIT_BASE = 8'd128;
  localparam logic [63:0] FRAME_SIZE = 64'd16;
  localparam logic [63:0] ALIGN_MASK = ~64'd15;

  typedef enum logic [2:0] {
    ACT_SEND        = 3'd0,
    ACT_DELIVER     = 3'd1,
    ACT_SIGRETURN   = 3'd2,
    ACT_EXEC_RESET  = 3'd3,
    ACT_SET_HANDLER = 3'd4,
    ACT_SET_BLOCKED = 3'd5,
    ACT_SET_RUN     = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    RS_READY   = 2'd0,
    RS_BLOCKED = 2'd1,
    RS_STOPPED = 2'd2,
    RS_ZOMBIE  = 2'd3
  } run_state_e;

  typedef enum logic [2:0] {
    OC_NONE    = 3'd0,
    OC_TERM    = 3'd1,
    OC_STOP    = 3'd2,
    OC_HANDLER = 3'd3,
    OC_IGNORED = 3'd4,
    OC_CONT    = 3'd5
  } outcome_e;

  typedef enum logic [1:0] {
    HK_DEFAULT = 2'd0,
    HK_IGNORE  = 2'd1,
    HK_CUSTOM  = 2'd2
  } handler_kind_e;

  typedef enum logic [1:0] {
    DA_TERM = 2'd0,
    DA_IGN  = 2'd1,
    DA_STOP = 2'd2,
    DA_CONT = 2'd3
  } def_act_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  signal_number;
    logic [1:0]  handler_kind;
    logic [63:0] handler_address;
    logic [63:0] handler_mask;
    logic        no_defer;
    logic [63:0] new_blocked_mask;
    logic [1:0]  new_run_state;
    logic [63:0] stack_pointer;
  } req_t;

  typedef struct packed {
    logic        out_status;
    logic        delivered;
    logic [2:0]  outcome;
    logic [1:0]  run_state_out;
    logic [7:0]  exit_status_out;
    logic [63:0] handler_entry;
    logic [5:0]  handler_arg;
    logic [63:0] new_stack_pointer;
    logic [63:0] pending_out;
    logic [63:0] blocked_out;
  } rsp_t;

  // One handler table row as stored in the RAM.
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] address;
    logic [63:0] mask;
    logic        nodefer;
  } hentry_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  // Default action by Linux signal number.
  function automatic def_act_e default_action(input logic [5:0] s);
    def_act_e da;
    da = DA_TERM;
    if (s == 6'd17 || s == 6'd23 || s == 6'd28) da = DA_IGN;
    else if (s == SIG_CONT) da = DA_CONT;
    else if (s >= 6'd19 && s <= 6'd22) da = DA_STOP;
    return da;
  endfunction

endpackage

>>> sv/spdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module spdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> sv/spdc_ctrl.sv
// Controller state machine: accept, execute, back to idle.
// Depends on spdc_pkg.
module spdc_ctrl
  import spdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    case (state)
      ST_IDLE: cmd.load = start;
      ST_EXEC: begin
        cmd.exec = 1'b1;
        busy     = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

>>> sv/spdc_datapath.sv
// Datapath: process state registers, handler table RAM with valid bits,
// lowest-pending search and the per-action update. Depends on spdc_pkg, spdc_ram.
module spdc_datapath
  import spdc_pkg::*;
#(
  parameter int SIGNAL_COUNT = SIGNAL_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  ctrl_cmd_t cmd,
  input  req_t      req,
  output rsp_t      rsp,
  output logic      done
);

  localparam int AW = $clog2(SIGNAL_COUNT);
  localparam int EW = $bits(hentry_t);

  // process state
  logic [63:0] pending, pending_next;
  logic [63:0] blocked, blocked_next;
  logic [63:0] saved, saved_next;
  logic        hdlr_active, hdlr_active_next;
  logic [1:0]  run_state, run_state_next;
  logic [7:0]  exit_code, exit_code_next;

  // table row valid and custom-kind flags
  logic [SIGNAL_COUNT-1:0] row_vld, row_vld_next;
  logic [SIGNAL_COUNT-1:0] row_cust, row_cust_next;

  // latched request and selection
  req_t       req_q;
  logic [5:0] sel_sig;
  logic       sel_any;
  logic       sel_vld;

  logic [63:0] sig_mask;
  logic [63:0] ready;
  logic [5:0]  sel;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  hentry_t       ram_wdata;
  logic [EW-1:0] ram_rdata;
  hentry_t       row;

  rsp_t        rsp_next;
  logic        sig_ok;
  logic [AW-1:0] sig_idx;
  logic [63:0] sig_bit;
  logic [63:0] sel_bit;

  // signals 1 .. SIGNAL_COUNT-1 can be delivered
  always_comb begin
    for (int i = 0; i < 64; i++) sig_mask[i] = (i >= 1) && (i < SIGNAL_COUNT);
  end

  // lowest unblocked pending signal, taken at accept
  assign ready = pending & ~blocked & sig_mask;
  always_comb begin
    sel = '0;
    for (int i = 63; i >= 0; i--) if (ready[i]) sel = 6'(i);
  end

  spdc_ram #(.WIDTH(EW), .DEPTH(SIGNAL_COUNT)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.load),
    .raddr (sel[AW-1:0]),
    .rdata (ram_rdata)
  );

  // a row never written reads as the reset entry
  assign row = sel_vld ? hentry_t'(ram_rdata) : '0;

  assign sig_ok  = (req_q.signal_number != 6'd0) &&
                   ({1'b0, req_q.signal_number} < 7'(SIGNAL_COUNT));
  assign sig_idx = req_q.signal_number[AW-1:0];
  assign sig_bit = 64'd1 << req_q.signal_number;
  assign sel_bit = 64'd1 << sel_sig;

  // per-action update
  always_comb begin
    pending_next     = pending;
    blocked_next     = blocked;
    saved_next       = saved;
    hdlr_active_next = hdlr_active;
    run_state_next   = run_state;
    exit_code_next   = exit_code;
    row_vld_next     = row_vld;
    row_cust_next    = row_cust;
    ram_we           = 1'b0;
    ram_waddr        = sig_idx;
    ram_wdata        = '{kind:    req_q.handler_kind,
                         address: req_q.handler_address,
                         mask:    req_q.handler_mask,
                         nodefer: req_q.no_defer};
    rsp_next         = '0;

    case (req_q.action)
      ACT_SEND: begin
        if (!sig_ok) begin
          rsp_next.out_status = 1'b1;
        end else if (req_q.signal_number == SIG_KILL) begin
          run_state_next   = RS_ZOMBIE;
          exit_code_next   = EXIT_BASE + {2'b00, req_q.signal_number};
          rsp_next.outcome = OC_TERM;
        end else if (req_q.signal_number == SIG_STOP) begin
          run_state_next   = RS_STOPPED;
          rsp_next.outcome = OC_STOP;
        end else begin
          if (req_q.signal_number == SIG_CONT && run_state == RS_STOPPED) begin
            run_state_next   = RS_READY;
            rsp_next.outcome = OC_CONT;
          end
          pending_next = pending | sig_bit;
          if (run_state_next == RS_BLOCKED && !blocked[req_q.signal_number])
            run_state_next = RS_READY;
        end
      end
      ACT_DELIVER: begin
        if (!hdlr_active && sel_any) begin
          pending_next = pending & ~sel_bit;
          if (row.kind == HK_IGNORE) begin
            rsp_next.outcome = OC_IGNORED;
          end else if (row.kind == HK_DEFAULT) begin
            case (default_action(sel_sig))
              DA_TERM: begin
                run_state_next     = RS_ZOMBIE;
                exit_code_next     = EXIT_BASE + {2'b00, sel_sig};
                rsp_next.outcome   = OC_TERM;
                rsp_next.delivered = 1'b1;
              end
              DA_IGN: rsp_next.outcome = OC_IGNORED;
              DA_STOP: begin
                run_state_next     = RS_STOPPED;
                rsp_next.outcome   = OC_STOP;
                rsp_next.delivered = 1'b1;
              end
              default: begin
                if (run_state == RS_STOPPED) begin
                  run_state_next   = RS_READY;
                  rsp_next.outcome = OC_CONT;
                end
              end
            endcase
          end else begin
            // custom handler: save mask, block, build frame
            saved_next   = blocked;
            blocked_next = blocked | row.mask | (row.nodefer ? 64'd0 : sel_bit);
            rsp_next.handler_entry     = row.address;
            rsp_next.handler_arg       = sel_sig;
            rsp_next.new_stack_pointer = (req_q.stack_pointer - FRAME_SIZE) & ALIGN_MASK;
            hdlr_active_next   = 1'b1;
            rsp_next.outcome   = OC_HANDLER;
            rsp_next.delivered = 1'b1;
          end
        end
      end
      ACT_SIGRETURN: begin
        blocked_next     = saved;
        hdlr_active_next = 1'b0;
      end
      ACT_EXEC_RESET: begin
        row_vld_next     = row_vld & ~row_cust;
        row_cust_next    = '0;
        hdlr_active_next = 1'b0;
      end
      ACT_SET_HANDLER: begin
        if (!sig_ok) begin
          rsp_next.out_status = 1'b1;
        end else begin
          ram_we                 = cmd.exec;
          row_vld_next[sig_idx]  = 1'b1;
          row_cust_next[sig_idx] = req_q.handler_kind[1];
        end
      end
      ACT_SET_BLOCKED: blocked_next = req_q.new_blocked_mask;
      ACT_SET_RUN: run_state_next = req_q.new_run_state;
      default: rsp_next.out_status = 1'b0;
    endcase

    rsp_next.run_state_out   = run_state_next;
    rsp_next.exit_status_out = exit_code_next;
    rsp_next.pending_out     = pending_next;
    rsp_next.blocked_out     = blocked_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= '0;
      blocked     <= '0;
      saved       <= '0;
      hdlr_active <= 1'b0;
      run_state   <= RS_READY;
      exit_code   <= '0;
      row_vld     <= '0;
      row_cust    <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.exec) begin
        pending     <= pending_next;
        blocked     <= blocked_next;
        saved       <= saved_next;
        hdlr_active <= hdlr_active_next;
        run_state   <= run_state_next;
        exit_code   <= exit_code_next;
        row_vld     <= row_vld_next;
        row_cust    <= row_cust_next;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q   <= req;
      sel_sig <= sel;
      sel_any <= |ready;
      sel_vld <= row_vld[sel[AW-1:0]];
    end
    if (cmd.exec) rsp <= rsp_next;
  end

endmodule

>>> sv/signal_pending_delivery_controller.sv
// Top level of the signal pending/delivery controller.
// Depends on spdc_pkg, spdc_ctrl, spdc_datapath (and spdc_ram below it).
//
// Usage:
//   Drive req and raise start; the transfer happens at the clock edge where
//   start is high and busy is low. busy is then high for one cycle while the
//   action executes. The result is registered at the edge after the
//   accepting one and sits on rsp with done high for exactly one cycle; it
//   is taken at the edge that ends that cycle. The receiver cannot stall
//   it, so it must take rsp whenever done is high.
//   Items are taken one at a time: while busy is high no new item is
//   accepted. The accepting cycle reads the handler table row of the lowest
//   deliverable signal from its registered RAM; the execute cycle applies
//   the action. A new item can be accepted in the cycle that shows done.
//   Exec reset takes no longer than any other action: table rows are tracked
//   by per-row valid and custom-kind flags, so no sweep is needed.
//   Reset (rst, synchronous) clears pending, blocked and saved masks, the
//   in-handler flag and exit code, sets the run state to ready and marks all
//   table rows as default; no clearing pass is needed.
module signal_pending_delivery_controller
  import spdc_pkg::*;
#(
  parameter int SIGNAL_COUNT = SIGNAL_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  ctrl_cmd_t cmd;

  spdc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  spdc_datapath #(.SIGNAL_COUNT(SIGNAL_COUNT)) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req),
    .rsp  (rsp),
    .done (done)
  );

endmodule

>>> sv/spdc_checker.sv
// Port-level checker for the signal pending/delivery controller, with bind.
// Depends on spdc_pkg and the assertion macro header.
`include "signal_pending_delivery_controller_defines.svh"

module spdc_checker
  import spdc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  // an accepted transfer executes next cycle
  `SPDC_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
  // execute yields a result in the next cycle, with busy low again
  `SPDC_ASSERT_NEXT(a_busy_done, busy, done && !busy)
  // a result only follows an execute cycle
  `SPDC_ASSERT_NOW(a_done_past, done, $past(busy))
  // entering a handler always counts as delivered
  `SPDC_ASSERT_NOW(a_handler_deliv, done && rsp.outcome == OC_HANDLER, rsp.delivered)

endmodule

bind signal_pending_delivery_controller spdc_checker u_spdc_checker (.*);

>>> tb/sv/signal_pending_delivery_controller_test.sv
// Testbench for the signal pending/delivery controller: directed and random
// transfers checked against a behavioral predictor. Depends on spdc_pkg.
`timescale 1ns / 100ps

module signal_pending_delivery_controller_test;
  import spdc_pkg::*;

  localparam int SIG_TOTAL   = SIGNAL_COUNT_DEF;
  localparam int RAND_ITEMS  = 800;
  localparam int CYCLE_LIMIT = 200000;

  // Result checker: holds the expected results in arrival order
  class delivery_scoreboard;
    rsp_t expected_q[$];
    int   mismatches;
    int   checked;

    function void note_item(rsp_t r);
      expected_q.push_back(r);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.out_status !== want.out_status || got.delivered !== want.delivered ||
          got.outcome !== want.outcome || got.run_state_out !== want.run_state_out ||
          got.exit_status_out !== want.exit_status_out ||
          got.handler_entry !== want.handler_entry ||
          got.handler_arg !== want.handler_arg ||
          got.new_stack_pointer !== want.new_stack_pointer ||
          got.pending_out !== want.pending_out ||
          got.blocked_out !== want.blocked_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on result %0d: expected %h actual %h", checked, want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  req_t req = '0;
  rsp_t rsp;

  delivery_scoreboard sb;
  int cycle_count = 0;
  int sent_count = 0;

  // Predictor state
  logic [63:0] pend_set, blk_mask, pred_saved;
  logic        pred_hdlr_active;
  logic [1:0]  run_state;
  logic [7:0]  exit_code;
  logic [1:0]  kind_tab [SIG_TOTAL];
  logic [63:0] addr_tab [SIG_TOTAL];
  logic [63:0] mask_tab [SIG_TOTAL];
  logic        nodefer_tab [SIG_TOTAL];

  signal_pending_delivery_controller uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .rsp(rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Results cannot be held off, so take every strobe
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(rsp);
  end

  function automatic logic sig_ok(logic [5:0] s);
    return s >= 1 && s < SIG_TOTAL;
  endfunction

  function automatic def_act_e dflt_action(logic [5:0] s);
    if (s == 17 || s == 23 || s == 28) return DA_IGN;
    if (s == SIG_CONT) return DA_CONT;
    if (s >= 19 && s <= 22) return DA_STOP;
    return DA_TERM;
  endfunction

  task automatic predict_reset();
    pend_set = '0; blk_mask = '0; pred_saved = '0; pred_hdlr_active = 1'b0;
    run_state = RS_READY; exit_code = '0;
    for (int i = 0; i < SIG_TOTAL; i++) begin
      kind_tab[i] = HK_DEFAULT; addr_tab[i] = '0; mask_tab[i] = '0; nodefer_tab[i] = 1'b0;
    end
  endtask

  // Compute the result of one accepted transfer and advance the state
  function automatic rsp_t predict_signal_step(req_t q);
    rsp_t r;
    logic [63:0] ready;
    logic [5:0] s;
    r = '0;
    case (q.action)
      ACT_SEND: begin
        if (!sig_ok(q.signal_number)) r.out_status = 1'b1;
        else if (q.signal_number == SIG_KILL) begin
          run_state = RS_ZOMBIE; exit_code = EXIT_BASE + {2'b00, q.signal_number};
          r.outcome = OC_TERM;
        end else if (q.signal_number == SIG_STOP) begin
          run_state = RS_STOPPED; r.outcome = OC_STOP;
        end else begin
          if (q.signal_number == SIG_CONT && run_state == RS_STOPPED) begin
            run_state = RS_READY; r.outcome = OC_CONT;
          end
          pend_set[q.signal_number] = 1'b1;
          if (run_state == RS_BLOCKED && !blk_mask[q.signal_number]) run_state = RS_READY;
        end
      end
      ACT_DELIVER: begin
        ready = pend_set & ~blk_mask & ~64'd1;
        if (!pred_hdlr_active && ready != 0) begin
          s = '0;
          for (int i = 63; i >= 0; i--) if (ready[i]) s = i[5:0];
          pend_set[s] = 1'b0;
          if (kind_tab[s] == HK_IGNORE) r.outcome = OC_IGNORED;
          else if (kind_tab[s] == HK_DEFAULT) begin
            case (dflt_action(s))
              DA_TERM: begin
                run_state = RS_ZOMBIE; exit_code = EXIT_BASE + {2'b00, s};
                r.outcome = OC_TERM; r.delivered = 1'b1;
              end
              DA_IGN: r.outcome = OC_IGNORED;
              DA_STOP: begin
                run_state = RS_STOPPED; r.outcome = OC_STOP; r.delivered = 1'b1;
              end
              default: if (run_state == RS_STOPPED) begin
                run_state = RS_READY; r.outcome = OC_CONT;
              end
            endcase
          end else begin
            pred_saved = blk_mask;
            blk_mask = blk_mask | mask_tab[s];
            if (!nodefer_tab[s]) blk_mask[s] = 1'b1;
            r.handler_entry = addr_tab[s];
            r.handler_arg = s;
            r.new_stack_pointer = (q.stack_pointer - FRAME_SIZE) & ALIGN_MASK;
            pred_hdlr_active = 1'b1; r.outcome = OC_HANDLER; r.delivered = 1'b1;
          end
        end
      end
      ACT_SIGRETURN: begin
        blk_mask = pred_saved; pred_hdlr_active = 1'b0;
      end
      ACT_EXEC_RESET: begin
        for (int i = 0; i < SIG_TOTAL; i++)
          if (kind_tab[i] >= HK_CUSTOM) begin
            kind_tab[i] = HK_DEFAULT; addr_tab[i] = '0; mask_tab[i] = '0; nodefer_tab[i] = 1'b0;
          end
        pred_hdlr_active = 1'b0;
      end
      ACT_SET_HANDLER: begin
        if (!sig_ok(q.signal_number)) r.out_status = 1'b1;
        else begin
          kind_tab[q.signal_number] = q.handler_kind;
          addr_tab[q.signal_number] = q.handler_address;
          mask_tab[q.signal_number] = q.handler_mask;
          nodefer_tab[q.signal_number] = q.no_defer;
        end
      end
      ACT_SET_BLOCKED: blk_mask = q.new_blocked_mask;
      ACT_SET_RUN: run_state = q.new_run_state;
      default: ;
    endcase
    r.run_state_out = run_state;
    r.exit_status_out = exit_code;
    r.pending_out = pend_set;
    r.blocked_out = blk_mask;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // One transfer: step off the previous edge, optional gap, hold start until accepted
  task automatic send_item(req_t q, int gap);
    repeat (gap + 1) @(posedge clk);
    req <= q;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(predict_signal_step(q));
    sent_count++;
    start <= 1'b0;
  endtask

  function automatic req_t make_item(logic [2:0] act, logic [5:0] sig);
    req_t q;
    q = '0;
    q.action = act;
    q.signal_number = sig;
    q.stack_pointer = rand64();
    return q;
  endfunction

  // Random content, biased toward sequences that reach delivery and handlers
  function automatic req_t random_item();
    req_t q;
    int pick;
    q.action = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 35) q.action = ACT_SEND;
    else if (pick < 60) q.action = ACT_DELIVER;
    else if (pick < 70) q.action = ACT_SIGRETURN;
    else if (pick < 82) q.action = ACT_SET_HANDLER;
    q.signal_number = ($urandom_range(0, 9) == 0) ? 6'($urandom()) : 6'($urandom_range(1, 31));
    q.handler_kind = 2'($urandom());
    q.handler_address = rand64();
    q.handler_mask = ($urandom_range(0, 1)) ? rand64() & rand64() & rand64() : rand64();
    q.no_defer = 1'($urandom());
    q.new_blocked_mask = ($urandom_range(0, 2) == 0) ? rand64() : rand64() & rand64() & rand64();
    q.new_run_state = ($urandom_range(0, 3) == 0) ? 2'($urandom()) : RS_READY;
    q.stack_pointer = rand64();
    return q;
  endfunction

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    req_t q;
    sb = new();
    predict_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: invalid signals, every action, kill/stop/cont, handlers
    send_item(make_item(ACT_SEND, 6'd0), 0);
    send_item(make_item(ACT_SET_HANDLER, 6'd0), 0);
    send_item(make_item(3'd7, 6'd5), 1);
    q = make_item(ACT_SET_HANDLER, 6'd10);
    q.handler_kind = HK_CUSTOM; q.handler_address = '1; q.handler_mask = '1;
    send_item(q, 0);
    q = make_item(ACT_SET_HANDLER, 6'd63);
    q.handler_kind = 2'd3; q.handler_address = 64'h8000_0000_0000_0001; q.no_defer = 1'b1;
    send_item(q, 0);
    q = make_item(ACT_SET_HANDLER, 6'd9); q.handler_kind = HK_CUSTOM;
    send_item(q, 2);
    send_item(make_item(ACT_SEND, 6'd19), 0);
    send_item(make_item(ACT_SEND, 6'd18), 0);
    send_item(make_item(ACT_DELIVER, 6'd0), 0);
    send_item(make_item(ACT_SEND, 6'd10), 0);
    send_item(make_item(ACT_SEND, 6'd63), 0);
    q = make_item(ACT_DELIVER, 6'd0); q.stack_pointer = '0;
    send_item(q, 0);
    send_item(make_item(ACT_DELIVER, 6'd0), 0);
    send_item(make_item(ACT_SIGRETURN, 6'd0), 3);
    q = make_item(ACT_DELIVER, 6'd0); q.stack_pointer = '1;
    send_item(q, 0);
    send_item(make_item(ACT_EXEC_RESET, 6'd0), 0);
    q = make_item(ACT_SET_RUN, 6'd0); q.new_run_state = RS_BLOCKED;
    send_item(q, 0);
    q = make_item(ACT_SET_BLOCKED, 6'd0); q.new_blocked_mask = '1;
    send_item(q, 0);
    send_item(make_item(ACT_SEND, 6'd17), 0);
    q = make_item(ACT_SET_BLOCKED, 6'd0); q.new_blocked_mask = '0;
    send_item(q, 0);
    send_item(make_item(ACT_SEND, 6'd2), 0);
    send_item(make_item(ACT_DELIVER, 6'd0), 0);
    send_item(make_item(ACT_DELIVER, 6'd0), 0);
    send_item(make_item(ACT_SEND, 6'd9), 0);

    // Hold off until the block has drained
    wait_drained();

    // Random part; revive the process now and then so delivery stays live
    for (int n = 0; n < RAND_ITEMS; n++) begin
      q = random_item();
      if (run_state == RS_ZOMBIE && $urandom_range(0, 3) == 0) begin
        q.action = ACT_SET_RUN; q.new_run_state = RS_READY;
      end
      if ($urandom_range(0, 199) == 0) wait_drained();
      send_item(q, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3));
    end

    wait_drained();
    repeat (5) @(posedge clk);
    $display("Ran %0d transfers covering send, deliver, handlers, sigreturn and exec reset;",
             sent_count);
    $display("%0d results checked, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
